// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, masked while reset is asserted
`define PMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on the rising clock that also holds during reset
`define PMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/pms_pkg.sv -----
// types and constants of the power mode sequencer
package pms_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfgIdxW = 2;

  // power modes
  typedef enum logic [ModeW-1:0] {
    MODE_STANDBY  = 3'd0,
    MODE_SLEEP    = 3'd1,
    MODE_COLDBOOT = 3'd2,
    MODE_RUNDOWN  = 3'd3,
    MODE_TURBO    = 3'd4,
    MODE_IGNITION = 3'd5,
    MODE_STARTING = 3'd6,
    MODE_RUNNING  = 3'd7
  } mode_e;

  // request codes
  localparam logic [ModeW-1:0] REQ_STANDBY  = 3'd0;
  localparam logic [ModeW-1:0] REQ_SLEEP    = 3'd1;
  localparam logic [ModeW-1:0] REQ_COLDBOOT = 3'd2;
  localparam logic [ModeW-1:0] REQ_RUNDOWN  = 3'd3;
  localparam logic [ModeW-1:0] REQ_RUNNING  = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STANDBY_ACCEPT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLEEP_ACCEPT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TURBO_HOLD     = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] standby_accept_time;
    logic [TimeW-1:0] sleep_accept_time;
    logic [TimeW-1:0] turbo_hold_time;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] switch_time;
    logic [TimeW-1:0] turbo_held;
  } state_t;

  typedef struct packed {
    mode_e            mode_now;
    logic             apply_standby;
    logic             apply_sleep;
    logic [TimeW-1:0] turbo_elapsed;
    logic             mode_changed;
  } result_t;

endpackage

// ----- rtl/pms_if.sv -----
// stream interfaces for ticks in and mode results out
interface pms_in_if import pms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_us;
  logic [ModeW-1:0] requested_mode;

  modport source (output valid, output now_us, output requested_mode, input ready);
  modport sink (input valid, input now_us, input requested_mode, output ready);
endinterface

interface pms_out_if import pms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode_now;
  logic             apply_standby;
  logic             apply_sleep;
  logic [TimeW-1:0] turbo_elapsed;
  logic             mode_changed;

  modport source (output valid, output mode_now, output apply_standby, output apply_sleep,
                  output turbo_elapsed, output mode_changed, input ready);
  modport sink (input valid, input mode_now, input apply_standby, input apply_sleep,
                input turbo_elapsed, input mode_changed, output ready);
endinterface

// ----- rtl/pms_step.sv -----
// combinational step: request table, elapsed time, apply pulses, turbo timeout
module pms_step import pms_pkg::*; (
  input  state_t           state_i,
  input  cfg_t             cfg_i,
  input  logic [TimeW-1:0] now_us_i,
  input  logic [ModeW-1:0] req_i,
  output state_t           state_o,
  output result_t          result_o
);

  mode_e            table_mode;
  mode_e            mode;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] held;

  // wrapping time since the last switch
  assign elapsed = now_us_i - state_i.switch_time;

  // request table, unused request codes fall to the last row
  always_comb begin
    table_mode = state_i.mode;
    unique case (state_i.mode)
      MODE_STANDBY, MODE_SLEEP: begin
        priority if (req_i == REQ_STANDBY) table_mode = MODE_STANDBY;
        else if (req_i == REQ_SLEEP)       table_mode = MODE_SLEEP;
        else                               table_mode = MODE_COLDBOOT;
      end
      MODE_COLDBOOT: begin
        priority if (req_i == REQ_STANDBY) table_mode = MODE_STANDBY;
        else if (req_i == REQ_SLEEP)       table_mode = MODE_SLEEP;
        else if (req_i == REQ_RUNDOWN)     table_mode = MODE_RUNDOWN;
        else if (req_i == REQ_RUNNING)     table_mode = MODE_IGNITION;
        else                               table_mode = MODE_COLDBOOT;
      end
      MODE_RUNDOWN: begin
        priority if (req_i == REQ_STANDBY) table_mode = MODE_STANDBY;
        else if (req_i == REQ_SLEEP)       table_mode = MODE_SLEEP;
        else if (req_i == REQ_COLDBOOT)    table_mode = MODE_COLDBOOT;
        else if (req_i == REQ_RUNNING)     table_mode = MODE_IGNITION;
        else                               table_mode = MODE_RUNDOWN;
      end
      MODE_TURBO: begin
        priority if (req_i <= REQ_COLDBOOT) table_mode = MODE_RUNDOWN;
        else if (req_i == REQ_RUNNING)      table_mode = MODE_IGNITION;
        else                                table_mode = MODE_TURBO;
      end
      MODE_IGNITION: begin
        if (req_i <= REQ_RUNDOWN) table_mode = MODE_RUNDOWN;
        else                      table_mode = MODE_IGNITION;
      end
      MODE_STARTING: begin
        if (req_i <= REQ_RUNDOWN) table_mode = MODE_IGNITION;
        else                      table_mode = MODE_STARTING;
      end
      MODE_RUNNING: begin
        if (req_i <= REQ_RUNDOWN) table_mode = MODE_TURBO;
        else                      table_mode = MODE_RUNNING;
      end
      default: table_mode = state_i.mode;
    endcase
  end

  // turbo timer sample and timeout
  always_comb begin
    held = state_i.turbo_held;
    mode = table_mode;
    if (state_i.mode == MODE_TURBO) begin
      held = elapsed;
      if (table_mode == MODE_TURBO && elapsed > cfg_i.turbo_hold_time) begin
        mode = MODE_RUNDOWN;
      end
    end
  end

  // next state
  assign state_o.mode        = mode;
  assign state_o.switch_time = (mode != state_i.mode) ? now_us_i : state_i.switch_time;
  assign state_o.turbo_held  = held;

  // result of this tick
  assign result_o.mode_now      = mode;
  assign result_o.apply_standby = (state_i.mode == MODE_STANDBY) && (mode == MODE_STANDBY) &&
                                  (elapsed > cfg_i.standby_accept_time);
  assign result_o.apply_sleep   = (state_i.mode == MODE_SLEEP) && (mode == MODE_SLEEP) &&
                                  (elapsed > cfg_i.sleep_accept_time);
  assign result_o.turbo_elapsed = held;
  assign result_o.mode_changed  = (mode != state_i.mode);

endmodule

// ----- rtl/power_mode_sequencer_unit.sv -----
// power mode sequencer top level: input register, mode state, result register
// path: an accepted tick is held in the input register, then its result in the result register
// throughput: one tick per cycle while results are taken, the step between registers is combinational
// while a result waits to be taken one more tick enters the input register, then input stalls
// reset (rst_ni low, asynchronous): mode standby, switch and turbo times zero,
// configuration registers zero, both pipeline registers empty
`include "assert_macros.svh"

module power_mode_sequencer_unit import pms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i,
  pms_in_if.sink             in_if,
  pms_out_if.source          out_if
);

  cfg_t             cfg_q;
  state_t           state_q, state_d;
  result_t          result_d, out_q;
  logic             s1_valid_q, out_valid_q;
  logic [TimeW-1:0] s1_now_q;
  logic [ModeW-1:0] s1_req_q;
  logic             s1_adv;
  logic             in_take;

  // handshakes
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign in_take     = in_if.valid && in_if.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STANDBY_ACCEPT: cfg_q.standby_accept_time <= cfg_wdata_i;
        CFG_SLEEP_ACCEPT:   cfg_q.sleep_accept_time   <= cfg_wdata_i;
        CFG_TURBO_HOLD:     cfg_q.turbo_hold_time     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q <= in_if.now_us;
      s1_req_q <= in_if.requested_mode;
    end
  end

  // one tick of the sequencer
  pms_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .now_us_i (s1_now_q),
    .req_i    (s1_req_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_STANDBY, switch_time: '0, turbo_held: '0};
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= result_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.mode_now      = out_q.mode_now;
  assign out_if.apply_standby = out_q.apply_standby;
  assign out_if.apply_sleep   = out_q.apply_sleep;
  assign out_if.turbo_elapsed = out_q.turbo_elapsed;
  assign out_if.mode_changed  = out_q.mode_changed;

  // checks
  `PMS_ASSERT(a_mode_tracks_result, clk_i, rst_ni, s1_adv |=> (state_q.mode == out_q.mode_now), "stored mode differs from reported mode")
  `PMS_ASSERT(a_switch_on_change, clk_i, rst_ni, (s1_adv && result_d.mode_changed) |=> (state_q.switch_time == $past(s1_now_q)), "switch time not taken on mode change")
  `PMS_ASSERT(a_apply_standby_mode, clk_i, rst_ni, (out_valid_q && out_q.apply_standby) |-> ((out_q.mode_now == MODE_STANDBY) && !out_q.mode_changed), "standby apply outside steady standby")
  `PMS_ASSERT_ALWAYS(a_sleep_apply_mode, clk_i, (out_valid_q && out_q.apply_sleep) |-> (out_q.mode_now == MODE_SLEEP), "sleep apply outside sleep")

endmodule

// ----- tb/tb_power_mode_sequencer_unit.sv -----
// testbench for the power mode sequencer: tick stream in, checked mode results out
`timescale 1ns / 1ps

module tb_power_mode_sequencer_unit;
  import pms_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 170;

  // write to this index must not touch any register
  localparam logic [CfgIdxW-1:0] CFG_NO_REG = 2'd3;

  // request codes with no meaning, they take the fallback row of the table
  localparam logic [ModeW-1:0] REQ_NONE_LO  = 3'd5;
  localparam logic [ModeW-1:0] REQ_NONE_MID = 3'd6;
  localparam logic [ModeW-1:0] REQ_NONE_HI  = 3'd7;

  // mode state tracker and queue of predicted results
  class mode_tracker;
    logic [TimeW-1:0] standby_accept;
    logic [TimeW-1:0] sleep_accept;
    logic [TimeW-1:0] turbo_hold;
    mode_e            mode;
    logic [TimeW-1:0] switch_time;
    logic [TimeW-1:0] turbo_held;
    result_t          pending_results[$];
    int               errors;
    int               ticks;
    int               standby_pulses;
    int               sleep_pulses;
    int               mode_changes;

    function new();
      standby_accept = '0;
      sleep_accept   = '0;
      turbo_hold     = '0;
      mode           = MODE_STANDBY;
      switch_time    = '0;
      turbo_held     = '0;
      errors         = 0;
      ticks          = 0;
      standby_pulses = 0;
      sleep_pulses   = 0;
      mode_changes   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] data);
      case (idx)
        CFG_STANDBY_ACCEPT: standby_accept = data;
        CFG_SLEEP_ACCEPT:   sleep_accept = data;
        CFG_TURBO_HOLD:     turbo_hold = data;
        default: ;
      endcase
    endfunction

    // request table
    function mode_e mode_after(mode_e from, logic [ModeW-1:0] req);
      case (from)
        MODE_STANDBY, MODE_SLEEP: begin
          if (req == REQ_STANDBY) return MODE_STANDBY;
          if (req == REQ_SLEEP) return MODE_SLEEP;
          return MODE_COLDBOOT;
        end
        MODE_COLDBOOT: begin
          if (req == REQ_STANDBY) return MODE_STANDBY;
          if (req == REQ_SLEEP) return MODE_SLEEP;
          if (req == REQ_RUNDOWN) return MODE_RUNDOWN;
          if (req == REQ_RUNNING) return MODE_IGNITION;
          return MODE_COLDBOOT;
        end
        MODE_RUNDOWN: begin
          if (req == REQ_STANDBY) return MODE_STANDBY;
          if (req == REQ_SLEEP) return MODE_SLEEP;
          if (req == REQ_COLDBOOT) return MODE_COLDBOOT;
          if (req == REQ_RUNNING) return MODE_IGNITION;
          return MODE_RUNDOWN;
        end
        MODE_TURBO: begin
          if (req <= REQ_COLDBOOT) return MODE_RUNDOWN;
          if (req == REQ_RUNNING) return MODE_IGNITION;
          return MODE_TURBO;
        end
        MODE_IGNITION: begin
          if (req <= REQ_RUNDOWN) return MODE_RUNDOWN;
          return MODE_IGNITION;
        end
        MODE_STARTING: begin
          if (req <= REQ_RUNDOWN) return MODE_IGNITION;
          return MODE_STARTING;
        end
        default: begin
          if (req <= REQ_RUNDOWN) return MODE_TURBO;
          return MODE_RUNNING;
        end
      endcase
    endfunction

    // advance the tracked state by one accepted tick transaction
    function void note_tick(logic [TimeW-1:0] now, logic [ModeW-1:0] req);
      result_t          res;
      mode_e            prev;
      mode_e            nxt;
      logic [TimeW-1:0] elapsed;
      prev    = mode;
      elapsed = now - switch_time;
      nxt     = mode_after(prev, req);
      res.apply_standby = (prev == MODE_STANDBY && nxt == MODE_STANDBY &&
                           elapsed > standby_accept);
      res.apply_sleep   = (prev == MODE_SLEEP && nxt == MODE_SLEEP &&
                           elapsed > sleep_accept);
      // turbo timer only runs on ticks that start in turbo
      if (prev == MODE_TURBO) begin
        turbo_held = elapsed;
        if (nxt == MODE_TURBO && elapsed > turbo_hold) nxt = MODE_RUNDOWN;
      end
      mode = nxt;
      if (nxt != prev) switch_time = now;
      res.mode_now      = nxt;
      res.turbo_elapsed = turbo_held;
      res.mode_changed  = (nxt != prev);
      pending_results.push_back(res);
      ticks++;
      if (res.apply_standby) standby_pulses++;
      if (res.apply_sleep) sleep_pulses++;
      if (res.mode_changed) mode_changes++;
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no tick pending: mode_now %0d", got.mode_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.mode_now !== want.mode_now) begin
        $error("mode_now: expected %0d, actual %0d", want.mode_now, got.mode_now);
        errors++;
      end
      if (got.apply_standby !== want.apply_standby) begin
        $error("apply_standby: expected %0b, actual %0b", want.apply_standby,
               got.apply_standby);
        errors++;
      end
      if (got.apply_sleep !== want.apply_sleep) begin
        $error("apply_sleep: expected %0b, actual %0b", want.apply_sleep, got.apply_sleep);
        errors++;
      end
      if (got.turbo_elapsed !== want.turbo_elapsed) begin
        $error("turbo_elapsed: expected %0d, actual %0d", want.turbo_elapsed,
               got.turbo_elapsed);
        errors++;
      end
      if (got.mode_changed !== want.mode_changed) begin
        $error("mode_changed: expected %0b, actual %0b", want.mode_changed,
               got.mode_changed);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TimeW-1:0] cfg_wdata_i;

  pms_in_if  in_bus ();
  pms_out_if out_bus ();

  mode_tracker tracker = new();

  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_request;
  int               settings;
  logic [TimeW-1:0] clock_us;

  power_mode_sequencer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_bus),
    .out_if      (out_bus)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // known values on every input from time zero
  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_wdata_i           = '0;
    in_bus.valid          = 1'b0;
    in_bus.now_us         = '0;
    in_bus.requested_mode = '0;
    out_bus.ready         = 1'b0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    hold_request          = 1'b0;
    settings              = 0;
    clock_us              = '0;
  end

  // one register write, we stays high for back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [TimeW-1:0] standby_us,
                              input logic [TimeW-1:0] sleep_us,
                              input logic [TimeW-1:0] hold_us);
    write_reg(CFG_STANDBY_ACCEPT, standby_us);
    write_reg(CFG_SLEEP_ACCEPT, sleep_us);
    write_reg(CFG_TURBO_HOLD, hold_us);
    write_reg(CFG_NO_REG, $urandom);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // offer one tick, return at the edge where it is accepted
  task automatic send_tick(input logic [TimeW-1:0] now, input logic [ModeW-1:0] req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.now_us         <= now;
    in_bus.requested_mode <= req;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.note_tick(now, req);
  endtask

  // wait until every predicted result has come back
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // random ticks: mostly short time steps so the accept compares get close calls
  task automatic run_phase(input int n, input int s_idle, input int r_idle,
                           input int stall_at);
    logic [ModeW-1:0] req;
    int               sel;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      if (i == stall_at) hold_request = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 70) clock_us = clock_us + $urandom_range(0, 40);
      else if (sel < 85) clock_us = clock_us + $urandom;
      else if (sel < 95) clock_us = $urandom;
      else clock_us = 32'hFFFF_FFFF - $urandom_range(0, 20);
      sel = $urandom_range(0, 99);
      if (sel < 30) req = REQ_STANDBY;
      else if (sel < 60) req = REQ_SLEEP;
      else if (sel < 72) req = REQ_COLDBOOT;
      else if (sel < 82) req = REQ_RUNDOWN;
      else if (sel < 94) req = REQ_RUNNING;
      else req = ModeW'($urandom_range(REQ_NONE_LO, REQ_NONE_HI));
      send_tick(clock_us, req);
    end
    in_bus.valid <= 1'b0;
    settle();
  endtask

  // result side: check each transaction, random ready, long hold on request
  initial begin : result_sink
    int      hold_left;
    result_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.mode_now      = mode_e'(out_bus.mode_now);
        got.apply_standby = out_bus.apply_standby;
        got.apply_sleep   = out_bus.apply_sleep;
        got.turbo_elapsed = out_bus.turbo_elapsed;
        got.mode_changed  = out_bus.mode_changed;
        tracker.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d idle cycles, %0d results pending", quiet, tracker.pending());
    $display("[power_mode_sequencer_unit] ERROR");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: strict compares, wrap of the elapsed time, the standby, sleep, coldboot, rundown and ignition rows
    program_regs(32'd10, 32'd20, 32'hFFFF_FFFF);
    send_tick(32'd0, REQ_STANDBY);
    send_tick(32'd10, REQ_STANDBY);
    send_tick(32'd11, REQ_STANDBY);
    send_tick(32'hFFFF_FFFF, REQ_STANDBY);
    send_tick(32'd100, REQ_SLEEP);
    send_tick(32'd120, REQ_SLEEP);
    send_tick(32'd121, REQ_SLEEP);
    send_tick(32'd50, REQ_SLEEP);
    send_tick(32'd60, REQ_NONE_LO);
    send_tick(32'd70, REQ_NONE_MID);
    send_tick(32'd80, REQ_RUNNING);
    send_tick(32'd90, REQ_NONE_HI);
    send_tick(32'd95, REQ_RUNNING);
    send_tick(32'd100, REQ_COLDBOOT);
    send_tick(32'd110, REQ_NONE_LO);
    send_tick(32'd120, REQ_RUNNING);
    send_tick(32'd130, REQ_STANDBY);
    send_tick(32'd140, REQ_COLDBOOT);
    send_tick(32'd150, REQ_RUNDOWN);
    send_tick(32'd160, REQ_SLEEP);
    send_tick(32'd170, REQ_STANDBY);
    send_tick(32'd180, REQ_RUNDOWN);
    send_tick(32'd190, REQ_SLEEP);
    send_tick(32'd200, REQ_NONE_HI);
    send_tick(32'd210, REQ_STANDBY);
    in_bus.valid <= 1'b0;
    clock_us = 32'd210;
    settle();

    // random phases with different idle patterns and register settings
    program_regs($urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60));
    run_phase(PHASE_TICKS, 29, 61, -1);
    program_regs(32'd0, 32'hFFFF_FFFF, 32'd0);
    run_phase(PHASE_TICKS, 61, 29, -1);
    program_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    run_phase(PHASE_TICKS, 0, 0, 50);
    program_regs($urandom, $urandom_range(0, 100), $urandom);
    run_phase(PHASE_TICKS, 0, 0, -1);

    $display("covered %0d ticks under %0d register settings, with idle, stall and streaming",
             tracker.ticks, settings);
    $display("saw %0d mode changes, %0d standby and %0d sleep apply pulses",
             tracker.mode_changes, tracker.standby_pulses, tracker.sleep_pulses);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[power_mode_sequencer_unit] OK");
    end else begin
      $display("[power_mode_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
